@@ design/rgu_pkg.sv @@
// ----------------------------------------------------------------------------
// Rectangle geometry unit package
// Operation codes and shared constants of the rectangle geometry unit.
// ----------------------------------------------------------------------------
package rgu_pkg;

  localparam int DEFAULT_COORD_BITS = 15;
  localparam int FUNC_WIDTH         = 3;
  localparam int NUM_PIECES         = 4;
  localparam int QUEUE_DEPTH        = 4;

  localparam logic [FUNC_WIDTH-1:0] FUNC_ENCLOSE   = 3'd0;
  localparam logic [FUNC_WIDTH-1:0] FUNC_SURROUND  = 3'd1;
  localparam logic [FUNC_WIDTH-1:0] FUNC_OVERLAP   = 3'd2;
  localparam logic [FUNC_WIDTH-1:0] FUNC_INTERSECT = 3'd3;
  localparam logic [FUNC_WIDTH-1:0] FUNC_UNION     = 3'd4;
  localparam logic [FUNC_WIDTH-1:0] FUNC_CUT       = 3'd5;

  localparam int PIECE_LEFT   = 0;
  localparam int PIECE_TOP    = 1;
  localparam int PIECE_RIGHT  = 2;
  localparam int PIECE_BOTTOM = 3;

endpackage

@@ design/rgu_front.sv @@
// ----------------------------------------------------------------------------
// Rectangle geometry unit front end
// Accepts input beats, forms the edges, and classifies each operation into a
// job: a single box with its flags, or a set of cut pieces to be emitted.
// ----------------------------------------------------------------------------
module rgu_front #(
  parameter int COORD_BITS = rgu_pkg::DEFAULT_COORD_BITS,
  localparam int JOB_WIDTH = 3 + rgu_pkg::NUM_PIECES + 8 * (COORD_BITS + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [rgu_pkg::FUNC_WIDTH-1:0] func,
  input  logic [COORD_BITS-1:0]          a_left,
  input  logic [COORD_BITS-1:0]          a_top,
  input  logic [COORD_BITS-1:0]          a_width,
  input  logic [COORD_BITS-1:0]          a_height,
  input  logic [COORD_BITS-1:0]          b_left,
  input  logic [COORD_BITS-1:0]          b_top,
  input  logic [COORD_BITS-1:0]          b_width,
  input  logic [COORD_BITS-1:0]          b_height,
  output logic                           job_valid,
  input  logic                           job_ready,
  output logic [JOB_WIDTH-1:0]           job
);
  import rgu_pkg::*;

  localparam int EW = COORD_BITS + 1;

  logic                  f_valid;
  logic [FUNC_WIDTH-1:0] f_func;
  logic [EW-1:0]         f_al, f_at, f_ar, f_ab, f_bl, f_bt, f_br, f_bb;
  logic                  load;

  logic [EW-1:0]         mxl, mxt, mnr, mnb;
  logic                  ovl;
  logic [NUM_PIECES-1:0] mask;
  logic                  single, ans, no_piece;
  logic [EW-1:0]         xl, xt, xr, xb;
  logic [NUM_PIECES-1:0] job_mask;

  assign load      = push && !full;
  assign full      = f_valid && !job_ready;
  assign job_valid = f_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (load) begin
      f_valid <= 1'b1;
    end else if (job_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      f_func <= func;
      f_al   <= {1'b0, a_left};
      f_at   <= {1'b0, a_top};
      f_ar   <= {1'b0, a_left} + {1'b0, a_width};
      f_ab   <= {1'b0, a_top} + {1'b0, a_height};
      f_bl   <= {1'b0, b_left};
      f_bt   <= {1'b0, b_top};
      f_br   <= {1'b0, b_left} + {1'b0, b_width};
      f_bb   <= {1'b0, b_top} + {1'b0, b_height};
    end
  end

  assign mxl = (f_al > f_bl) ? f_al : f_bl;
  assign mxt = (f_at > f_bt) ? f_at : f_bt;
  assign mnr = (f_ar < f_br) ? f_ar : f_br;
  assign mnb = (f_ab < f_bb) ? f_ab : f_bb;
  assign ovl = (mxl < mnr) && (mxt < mnb);

  assign mask[PIECE_LEFT]   = (f_al < f_bl) && (f_at < f_ab);
  assign mask[PIECE_TOP]    = (mxl < mnr) && (f_at < f_bt);
  assign mask[PIECE_RIGHT]  = (f_br < f_ar) && (f_at < f_ab) && !f_br[EW-1];
  assign mask[PIECE_BOTTOM] = (mxl < mnr) && (f_bb < f_ab) && !f_bb[EW-1];

  always_comb begin
    single   = 1'b1;
    ans      = 1'b0;
    no_piece = 1'b0;
    job_mask = '0;
    xl       = '0;
    xt       = '0;
    xr       = '0;
    xb       = '0;
    unique case (f_func)
      FUNC_ENCLOSE: begin
        ans = (f_al <= f_bl) && (f_at <= f_bt) && (f_ar >= f_br) && (f_ab >= f_bb);
      end
      FUNC_SURROUND: begin
        ans = (f_al < f_bl) && (f_at < f_bt) && (f_ar > f_br) && (f_ab > f_bb);
      end
      FUNC_OVERLAP: begin
        ans = ovl;
      end
      FUNC_INTERSECT: begin
        xl = mxl;
        xt = mxt;
        xr = ovl ? mnr : mxl;
        xb = ovl ? mnb : mxt;
      end
      FUNC_UNION: begin
        xl = (f_al < f_bl) ? f_al : f_bl;
        xt = (f_at < f_bt) ? f_at : f_bt;
        xr = (f_ar > f_br) ? f_ar : f_br;
        xb = (f_ab > f_bb) ? f_ab : f_bb;
      end
      FUNC_CUT: begin
        if (!ovl) begin
          xl = f_al;
          xt = f_at;
          xr = f_ar;
          xb = f_ab;
        end else if (mask == '0) begin
          no_piece = 1'b1;
        end else begin
          single   = 1'b0;
          job_mask = mask;
          xl       = f_al;
          xt       = f_at;
          xr       = f_ar;
          xb       = f_ab;
        end
      end
      default: begin
      end
    endcase
  end

  assign job = {single, ans, no_piece, job_mask, xl, xt, xr, xb, f_bl, f_bt, f_br, f_bb};

endmodule

@@ design/rgu_queue.sv @@
// ----------------------------------------------------------------------------
// Rectangle geometry unit job queue
// Small first-in first-out store that decouples the front end from the back
// end.
// ----------------------------------------------------------------------------
module rgu_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rgu_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_pop,
  output logic [WIDTH-1:0] rd_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr, do_rd;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;
  assign rd_data  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ design/rgu_back.sv @@
// ----------------------------------------------------------------------------
// Rectangle geometry unit back end
// Takes jobs from the queue and emits their results, one cut piece per cycle
// while the output register is empty or being popped, through that register.
// ----------------------------------------------------------------------------
module rgu_back #(
  parameter int COORD_BITS = rgu_pkg::DEFAULT_COORD_BITS,
  localparam int JOB_WIDTH = 3 + rgu_pkg::NUM_PIECES + 8 * (COORD_BITS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  output logic                  job_pop,
  input  logic [JOB_WIDTH-1:0]  job,
  output logic                  empty,
  input  logic                  pop,
  output logic                  answer,
  output logic [COORD_BITS-1:0] out_left,
  output logic [COORD_BITS-1:0] out_top,
  output logic [COORD_BITS:0]   out_width,
  output logic [COORD_BITS:0]   out_height,
  output logic                  no_piece,
  output logic                  last
);
  import rgu_pkg::*;

  localparam int EW = COORD_BITS + 1;

  logic                  single, ans, np;
  logic [NUM_PIECES-1:0] mask, done, rem, sel;
  logic [EW-1:0]         al, at, ar, ab, bl, bt, br, bb;
  logic [EW-1:0]         mxl, mnr, pl, pt, pr, pb;
  logic                  last_piece, fin, adv, o_valid;

  assign {single, ans, np, mask, al, at, ar, ab, bl, bt, br, bb} = job;

  assign rem        = mask & ~done;
  assign sel        = rem & (~rem + 1'b1);
  assign last_piece = ((rem & ~sel) == '0);
  assign fin        = single || last_piece;
  assign adv        = job_valid && (!o_valid || pop);
  assign job_pop    = adv && fin;
  assign empty      = !o_valid;

  assign mxl = (al > bl) ? al : bl;
  assign mnr = (ar < br) ? ar : br;

  always_comb begin
    pl = al;
    pt = at;
    pr = ar;
    pb = ab;
    if (!single) begin
      priority if (sel[PIECE_LEFT]) begin
        pr = bl;
      end else if (sel[PIECE_TOP]) begin
        pl = mxl;
        pr = mnr;
        pb = bt;
      end else if (sel[PIECE_RIGHT]) begin
        pl = br;
      end else begin
        pl = mxl;
        pt = bb;
        pr = mnr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      done    <= '0;
    end else begin
      if (adv) begin
        o_valid <= 1'b1;
        done    <= fin ? '0 : (done | sel);
      end else if (pop) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      answer     <= ans;
      out_left   <= pl[COORD_BITS-1:0];
      out_top    <= pt[COORD_BITS-1:0];
      out_width  <= pr - pl;
      out_height <= pb - pt;
      no_piece   <= np;
      last       <= fin;
    end
  end

endmodule

@@ design/rectangle_geometry_unit_top.sv @@
// ----------------------------------------------------------------------------
// Rectangle geometry unit
// Throughput: one input beat per cycle for single-result operations while
// the queue has room and the output is popped; a cut emits one piece (one to
// four) per cycle, paced by the back end's single output register. Reset
// clears the valid flags and queue pointers.
// ----------------------------------------------------------------------------
module rectangle_geometry_unit_top #(
  parameter int COORD_BITS = rgu_pkg::DEFAULT_COORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [rgu_pkg::FUNC_WIDTH-1:0] func,
  input  logic [COORD_BITS-1:0]          a_left,
  input  logic [COORD_BITS-1:0]          a_top,
  input  logic [COORD_BITS-1:0]          a_width,
  input  logic [COORD_BITS-1:0]          a_height,
  input  logic [COORD_BITS-1:0]          b_left,
  input  logic [COORD_BITS-1:0]          b_top,
  input  logic [COORD_BITS-1:0]          b_width,
  input  logic [COORD_BITS-1:0]          b_height,
  output logic                           empty,
  input  logic                           pop,
  output logic                           answer,
  output logic [COORD_BITS-1:0]          out_left,
  output logic [COORD_BITS-1:0]          out_top,
  output logic [COORD_BITS:0]            out_width,
  output logic [COORD_BITS:0]            out_height,
  output logic                           no_piece,
  output logic                           last
);
  import rgu_pkg::*;

  localparam int JOB_WIDTH = 3 + NUM_PIECES + 8 * (COORD_BITS + 1);

  logic                 fq_valid, fq_ready, qb_valid, qb_pop;
  logic [JOB_WIDTH-1:0] fq_job, qb_job;

  rgu_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .a_left    (a_left),
    .a_top     (a_top),
    .a_width   (a_width),
    .a_height  (a_height),
    .b_left    (b_left),
    .b_top     (b_top),
    .b_width   (b_width),
    .b_height  (b_height),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  rgu_queue #(.WIDTH(JOB_WIDTH), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_job),
    .rd_valid (qb_valid),
    .rd_pop   (qb_pop),
    .rd_data  (qb_job)
  );

  rgu_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (qb_valid),
    .job_pop    (qb_pop),
    .job        (qb_job),
    .empty      (empty),
    .pop        (pop),
    .answer     (answer),
    .out_left   (out_left),
    .out_top    (out_top),
    .out_width  (out_width),
    .out_height (out_height),
    .no_piece   (no_piece),
    .last       (last)
  );

  a_no_piece_last: assert property (@(posedge clk) disable iff (rst)
    !empty && no_piece |-> last)
    else $error("empty cut result is not the last beat");

  a_answer_no_box: assert property (@(posedge clk) disable iff (rst)
    !empty && answer |-> out_width == '0 && out_height == '0 && !no_piece)
    else $error("test result carries a box");

  a_inner_piece: assert property (@(posedge clk) disable iff (rst)
    !empty && !last |-> !answer && !no_piece && out_width != '0 && out_height != '0)
    else $error("non-final beat is not a cut piece");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (rst)
    qb_pop |-> qb_valid)
    else $error("back end took a job from an empty queue");

endmodule
